[src/pcc_pkg.sv]
`timescale 1ns / 1ps

package pcc_pkg;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int ADDR_W = 11;
  localparam int BYTE_W = 8;
  localparam int HALF_W = 16;
  localparam int PTR_W  = 17;
  localparam int STEP_W = 5;

  // Pointer layout and acceptance limits
  localparam int PTR_SPAN = 4;
  localparam int MIN_LEN  = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses
  localparam step_t S_RST_CLR  = 5'd0;
  localparam step_t S_IDLE     = 5'd1;
  localparam step_t S_LOAD     = 5'd2;
  localparam step_t S_RD0      = 5'd3;
  localparam step_t S_RD1      = 5'd4;
  localparam step_t S_CLR      = 5'd5;
  localparam step_t S_CK_KNOWN = 5'd6;
  localparam step_t S_CK_RD    = 5'd7;
  localparam step_t S_CK_CAP   = 5'd8;
  localparam step_t S_CK_TEST  = 5'd9;
  localparam step_t S_SCAN_RD  = 5'd10;
  localparam step_t S_SCAN_CHK = 5'd11;
  localparam step_t S_SCAN_END = 5'd12;
  localparam step_t S_MARK     = 5'd13;
  localparam step_t S_MARKP    = 5'd14;
  localparam step_t S_FOUND    = 5'd15;
  localparam step_t S_DONE     = 5'd16;

  typedef enum logic [3:0] {
    COND_ALWAYS    = 4'd0,
    COND_REQ       = 4'd1,
    COND_CNT_END   = 4'd2,
    COND_CNT_PTR   = 4'd3,
    COND_PTR_BAD   = 4'd4,
    COND_SCAN_STOP = 4'd5,
    COND_OWN_NZ    = 4'd6,
    COND_CNT_LEN   = 4'd7,
    COND_OUT_FREE  = 4'd8
  } cond_t;

  typedef enum logic {
    CNT_HOLD = 1'b0,
    CNT_STEP = 1'b1
  } cnt_op_t;

  typedef enum logic [1:0] {
    OA_CNT = 2'd0,
    OA_A   = 2'd1,
    OA_S   = 2'd2
  } oaddr_t;

  typedef enum logic [1:0] {
    OW_NONE  = 2'd0,
    OW_ON    = 2'd1,
    OW_KNOWN = 2'd2
  } owe_t;

  // One control word of the microprogram
  typedef struct packed {
    cond_t   cond;
    step_t   jt;
    step_t   jf;
    logic    dispatch;
    logic    take_in;
    cnt_op_t cnt_op;
    oaddr_t  oaddr_sel;
    owe_t    owe;
    logic    owd_a;
    logic    own_re;
    logic    byte_we;
    logic    byte_re;
    logic    cap_byte;
    logic    cap_read;
    logic    set_found;
    logic    out_load;
  } ctrl_t;

  // Datapath conditions fed back to the sequencer
  typedef struct packed {
    logic cnt_end;
    logic cnt_ptr;
    logic cnt_len;
    logic ptr_bad;
    logic own_nz;
    logic out_free;
  } status_t;

  // Entry point of each operation
  function automatic step_t pcc_entry(input logic [FUNC_W-1:0] f);
    step_t s;
    case (f)
      FUNC_LOAD:  s = S_LOAD;
      FUNC_CHECK: s = S_CK_KNOWN;
      FUNC_READ:  s = S_RD0;
      FUNC_CLEAR: s = S_CLR;
      default:    s = S_IDLE;
    endcase
    return s;
  endfunction

  // Microprogram store
  function automatic ctrl_t pcc_rom(input step_t s);
    ctrl_t c;
    c = '0;
    c.cond = COND_ALWAYS;
    c.cnt_op = CNT_HOLD;
    c.oaddr_sel = OA_CNT;
    c.owe = OW_NONE;
    c.jt = S_IDLE;
    c.jf = S_IDLE;
    case (s)
      S_RST_CLR: begin
        c.cond = COND_CNT_END; c.jt = S_IDLE; c.jf = S_RST_CLR;
        c.owe = OW_ON; c.oaddr_sel = OA_CNT; c.cnt_op = CNT_STEP;
      end
      S_IDLE: begin
        c.cond = COND_REQ; c.dispatch = 1'b1; c.jf = S_IDLE; c.take_in = 1'b1;
      end
      S_LOAD: begin
        c.jt = S_DONE; c.byte_we = 1'b1;
      end
      S_RD0: begin
        c.jt = S_RD1; c.byte_re = 1'b1; c.own_re = 1'b1; c.oaddr_sel = OA_A;
      end
      S_RD1: begin
        c.jt = S_DONE; c.cap_read = 1'b1;
      end
      S_CLR: begin
        c.cond = COND_CNT_END; c.jt = S_DONE; c.jf = S_CLR;
        c.owe = OW_ON; c.oaddr_sel = OA_CNT; c.cnt_op = CNT_STEP;
      end
      S_CK_KNOWN: begin
        c.cond = COND_CNT_PTR; c.jt = S_CK_RD; c.jf = S_CK_KNOWN;
        c.owe = OW_KNOWN; c.owd_a = 1'b1; c.oaddr_sel = OA_A; c.cnt_op = CNT_STEP;
      end
      S_CK_RD: begin
        c.jt = S_CK_CAP; c.byte_re = 1'b1;
      end
      S_CK_CAP: begin
        c.cond = COND_CNT_PTR; c.jt = S_CK_TEST; c.jf = S_CK_RD;
        c.cap_byte = 1'b1; c.cnt_op = CNT_STEP;
      end
      S_CK_TEST: begin
        c.cond = COND_PTR_BAD; c.jt = S_DONE; c.jf = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        c.jt = S_SCAN_CHK; c.own_re = 1'b1; c.oaddr_sel = OA_S;
      end
      S_SCAN_CHK: begin
        c.cond = COND_SCAN_STOP; c.jt = S_SCAN_END; c.jf = S_SCAN_RD;
        c.cnt_op = CNT_STEP;
      end
      S_SCAN_END: begin
        c.cond = COND_OWN_NZ; c.jt = S_DONE; c.jf = S_MARK;
      end
      S_MARK: begin
        c.cond = COND_CNT_LEN; c.jt = S_MARKP; c.jf = S_MARK;
        c.owe = OW_ON; c.owd_a = 1'b1; c.oaddr_sel = OA_S; c.cnt_op = CNT_STEP;
      end
      S_MARKP: begin
        c.cond = COND_CNT_PTR; c.jt = S_FOUND; c.jf = S_MARKP;
        c.owe = OW_ON; c.owd_a = 1'b1; c.oaddr_sel = OA_A; c.cnt_op = CNT_STEP;
      end
      S_FOUND: begin
        c.jt = S_DONE; c.set_found = 1'b1;
      end
      S_DONE: begin
        c.cond = COND_OUT_FREE; c.jt = S_IDLE; c.jf = S_DONE; c.out_load = 1'b1;
      end
      default: begin
        c.jt = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

[src/pcc_ram.sv]
`timescale 1ns / 1ps

module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pcc_seq.sv]
`timescale 1ns / 1ps

module pcc_seq
  import pcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_accept,
  input  logic [FUNC_W-1:0]   func,
  input  status_t             status,
  output ctrl_t               ctrl,
  output logic                jump
);

  step_t step;
  step_t step_next;

  // Fetch the control word of the current step
  assign ctrl = pcc_rom(step);

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:    jump = 1'b1;
      COND_REQ:       jump = req_accept;
      COND_CNT_END:   jump = status.cnt_end;
      COND_CNT_PTR:   jump = status.cnt_ptr;
      COND_PTR_BAD:   jump = status.ptr_bad;
      COND_SCAN_STOP: jump = status.own_nz | status.cnt_len;
      COND_OWN_NZ:    jump = status.own_nz;
      COND_CNT_LEN:   jump = status.cnt_len;
      COND_OUT_FREE:  jump = status.out_free;
      default:        jump = 1'b0;
    endcase
  end

  // Pick the next step
  always_comb begin
    if (!jump) begin
      step_next = ctrl.jf;
    end else if (ctrl.dispatch) begin
      step_next = pcc_entry(func);
    end else begin
      step_next = ctrl.jt;
    end
  end

  // Start with the owner map clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_RST_CLR;
    end else begin
      step <= step_next;
    end
  end

endmodule

[src/pcc_dp.sv]
`timescale 1ns / 1ps

module pcc_dp
  import pcc_pkg::*;
#(
  parameter int BLOCK_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic                jump,
  input  logic                req_accept,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [BYTE_W-1:0]   data,
  input  logic                known,
  output status_t             status,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                found,
  output logic [ADDR_W-1:0]   owner,
  output logic [BYTE_W-1:0]   byte_value
);

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam logic [PTR_W-1:0] BLK = PTR_W'(BLOCK_BYTES);

  logic [ADDR_W-1:0]   a_reg;
  logic [BYTE_W-1:0]   d_reg;
  logic                known_reg;
  logic [AW-1:0]       cnt;
  logic [2*HALF_W-1:0] ptr_word;
  logic                res_found;
  logic [ADDR_W-1:0]   res_owner;
  logic [BYTE_W-1:0]   res_byte;

  logic [HALF_W-1:0]   s_val;
  logic [HALF_W-1:0]   l_val;
  logic [PTR_W-1:0]    cnt_ext;
  logic [PTR_W-1:0]    a_off;
  logic [PTR_W-1:0]    s_off;
  logic [PTR_W-1:0]    oaddr;
  logic                own_rng;
  logic                byte_rng;
  logic                own_we;
  logic [ADDR_W-1:0]   own_wdata;
  logic [ADDR_W-1:0]   own_rdata;
  logic [BYTE_W-1:0]   byte_rdata;

  assign s_val   = ptr_word[HALF_W-1:0];
  assign l_val   = ptr_word[2*HALF_W-1:HALF_W];
  assign cnt_ext = PTR_W'(cnt);
  assign a_off   = PTR_W'(a_reg) + cnt_ext;
  assign s_off   = PTR_W'(s_val) + cnt_ext;

  // Select the owner map address
  always_comb begin
    case (ctrl.oaddr_sel)
      OA_CNT:  oaddr = cnt_ext;
      OA_A:    oaddr = a_off;
      OA_S:    oaddr = s_off;
      default: oaddr = cnt_ext;
    endcase
  end

  assign own_rng  = oaddr < BLK;
  assign byte_rng = a_off < BLK;

  // Drop owner writes past the end
  always_comb begin
    case (ctrl.owe)
      OW_ON:    own_we = own_rng;
      OW_KNOWN: own_we = own_rng & known_reg;
      default:  own_we = 1'b0;
    endcase
  end

  assign own_wdata = ctrl.owd_a ? a_reg : '0;

  pcc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (BLOCK_BYTES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (oaddr[AW-1:0]),
    .wdata (own_wdata),
    .re    (ctrl.own_re & own_rng),
    .raddr (oaddr[AW-1:0]),
    .rdata (own_rdata)
  );

  pcc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BLOCK_BYTES)
  ) u_byte_ram (
    .clk   (clk),
    .we    (ctrl.byte_we & byte_rng),
    .waddr (a_off[AW-1:0]),
    .wdata (d_reg),
    .re    (ctrl.byte_re & byte_rng),
    .raddr (a_off[AW-1:0]),
    .rdata (byte_rdata)
  );

  // Conditions for the sequencer
  assign status.cnt_end  = cnt == AW'(BLOCK_BYTES - 1);
  assign status.cnt_ptr  = cnt[1:0] == 2'(PTR_SPAN - 1);
  assign status.cnt_len  = cnt_ext == (PTR_W'(l_val) - PTR_W'(1));
  assign status.ptr_bad  = (s_val == '0) || (l_val < HALF_W'(MIN_LEN)) ||
                           (PTR_W'(s_val) > BLK) || (PTR_W'(l_val) > BLK) ||
                           ((PTR_W'(s_val) + PTR_W'(l_val)) > BLK);
  assign status.own_nz   = own_rdata != '0;
  assign status.out_free = !rsp_valid || !rsp_stall;

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (req_accept) begin
      a_reg     <= addr;
      d_reg     <= data;
      known_reg <= known;
    end
  end

  // Step the loop counter, wrapping when the loop exits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req_accept) begin
      cnt <= '0;
    end else if (ctrl.cnt_op == CNT_STEP) begin
      cnt <= jump ? '0 : cnt + AW'(1);
    end
  end

  // Assemble start and length little endian, zero past the end
  always_ff @(posedge clk) begin
    if (ctrl.cap_byte) begin
      ptr_word <= {(byte_rng ? byte_rdata : '0), ptr_word[2*HALF_W-1:BYTE_W]};
    end
  end

  // Build the result of the current operation
  always_ff @(posedge clk) begin
    if (req_accept) begin
      res_found <= 1'b0;
      res_owner <= '0;
      res_byte  <= '0;
    end else begin
      if (ctrl.set_found) begin
        res_found <= 1'b1;
      end
      if (ctrl.cap_read) begin
        res_owner <= byte_rng ? own_rdata : '0;
        res_byte  <= byte_rng ? byte_rdata : '0;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.out_load && status.out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && status.out_free) begin
      found      <= res_found;
      owner      <= res_owner;
      byte_value <= res_byte;
    end
  end

endmodule

[src/pointer_chunk_claim_map.sv]
`timescale 1ns / 1ps

// Byte store with a per-byte owner map, run by a small microprogram over two
// single-port RAMs. One request is taken at a time; the result sits in an
// output register so the next request can be taken while it waits. After
// reset the owner map is cleared with req_stall high. A check ends early
// when the range is rejected. The owner map port sets the check cost: the
// range is walked once to test (each entry read, then compared) and once
// to claim.
module pointer_chunk_claim_map
  import pcc_pkg::*;
#(
  parameter int BLOCK_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [BYTE_W-1:0]   data,
  input  logic                known,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                found,
  output logic [ADDR_W-1:0]   owner,
  output logic [BYTE_W-1:0]   byte_value
);

  ctrl_t   ctrl;
  status_t status;
  logic    jump;
  logic    req_accept;

  // Take a request only in the idle step
  assign req_stall  = !ctrl.take_in;
  assign req_accept = req_valid && ctrl.take_in;

  pcc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_accept (req_accept),
    .func       (func),
    .status     (status),
    .ctrl       (ctrl),
    .jump       (jump)
  );

  pcc_dp #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .jump       (jump),
    .req_accept (req_accept),
    .addr       (addr),
    .data       (data),
    .known      (known),
    .status     (status),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .found      (found),
    .owner      (owner),
    .byte_value (byte_value)
  );

  // A found check never carries read-back data
  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(found && ((owner != '0) || (byte_value != '0))))
    else $error("found set together with read-back data");

  // Requests are taken one at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken in back-to-back cycles");

  // Owner map clearing pass blocks requests after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> req_stall)
    else $error("request taken before owner map clearing");

  // Result register is only loaded when free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !(ctrl.out_load && status.out_free))
    else $error("waiting result overwritten");

endmodule
